@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. All assume a clock named clk and an
// active-high reset named rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

@@ rtl/i2cwm_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cwm_pkg
// Types and constants shared by the I2C write master sequencer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cwm_pkg;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_BYTE  = 2'd1,
    ACT_STOP  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd120;
  localparam logic [3:0]  BIT_ACK           = 4'd8;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic        scl_level;
    logic        sda_level;
    logic [15:0] hold_cycles;
    logic        last;
  } out_item_t;

  typedef struct packed {
    action_t    kind;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

endpackage

@@ rtl/i2cwm_front.sv @@
// ----------------------------------------------------------------------------
// i2cwm_front
// Accepts command beats, drops unknown actions and holds up to two
// commands for the line sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2cwm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  i2cwm_pkg::in_item_t in_item,
  output i2cwm_pkg::head_t    head,
  input  logic                deq
);

  i2cwm_pkg::cmd_t mem [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic [1:0]      count_next;
  logic            enq;

  assign full = (count == 2'd2);
  assign enq  = push && !full &&
                (i2cwm_pkg::action_t'(in_item.action) != i2cwm_pkg::ACT_NONE);

  always_comb begin
    count_next = count;
    if (enq && !deq) begin
      count_next = count + 2'd1;
    end else if (deq && !enq) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (enq) begin
        wr_ptr <= ~wr_ptr;
      end
      if (deq) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      mem[wr_ptr] <= '{kind: i2cwm_pkg::action_t'(in_item.action),
                       data: in_item.data_byte};
    end
  end

  assign head.valid = (count != 2'd0);
  assign head.cmd   = mem[rd_ptr];

  `ASSERT_CLK(a_deq_not_empty, deq |-> (count != 2'd0), "Command taken from an empty queue.")
  `ASSERT_NEVER(a_count_range, count == 2'd3, "Command queue count out of range.")

endmodule

@@ rtl/i2cwm_back.sv @@
// ----------------------------------------------------------------------------
// i2cwm_back
// Line sequencer: steps the head command through its line states into a
// result register, one per cycle while that register is empty or popped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2cwm_back (
  input  logic                 clk,
  input  logic                 rst,
  input  i2cwm_pkg::head_t     head,
  output logic                 deq,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata,
  output logic                 empty,
  input  logic                 pop,
  output i2cwm_pkg::out_item_t out_item
);

  typedef enum logic [2:0] {
    PH_LEAD = 3'b001,
    PH_HIGH = 3'b010,
    PH_LOW  = 3'b100
  } phase_t;

  phase_t               phase;
  phase_t               phase_next;
  logic [3:0]           bitcnt;
  logic [3:0]           bitcnt_next;
  logic                 scl_now;
  logic [15:0]          half;
  logic                 out_valid;
  i2cwm_pkg::out_item_t out_reg;
  i2cwm_pkg::out_item_t nxt;
  logic                 adv;
  logic                 bit_val;
  logic                 delayed;

  assign adv = head.valid && (!out_valid || pop);

  always_comb begin
    bit_val = (bitcnt == i2cwm_pkg::BIT_ACK) ? 1'b1
            : head.cmd.data[3'd7 - bitcnt[2:0]];
    nxt     = '0;
    delayed = 1'b0;
    case (head.cmd.kind)
      i2cwm_pkg::ACT_START: begin
        case (phase)
          PH_LEAD: begin nxt.scl_level = 1'b1; nxt.sda_level = 1'b1; delayed = 1'b1; end
          PH_HIGH: begin nxt.scl_level = 1'b1; nxt.sda_level = 1'b0; delayed = 1'b1; end
          PH_LOW:  begin nxt.scl_level = 1'b0; nxt.sda_level = 1'b0; nxt.last = 1'b1; end
          default: nxt = '0;
        endcase
      end
      i2cwm_pkg::ACT_STOP: begin
        case (phase)
          PH_LEAD: begin nxt.scl_level = scl_now; nxt.sda_level = 1'b0; end
          PH_HIGH: begin nxt.scl_level = 1'b1; nxt.sda_level = 1'b0; delayed = 1'b1; end
          PH_LOW: begin
            nxt.scl_level = 1'b1;
            nxt.sda_level = 1'b1;
            delayed       = 1'b1;
            nxt.last      = 1'b1;
          end
          default: nxt = '0;
        endcase
      end
      i2cwm_pkg::ACT_BYTE: begin
        nxt.sda_level = bit_val;
        case (phase)
          PH_LEAD: begin nxt.scl_level = scl_now; delayed = 1'b1; end
          PH_HIGH: begin nxt.scl_level = 1'b1; delayed = 1'b1; end
          PH_LOW: begin
            nxt.scl_level = 1'b0;
            nxt.last      = (bitcnt == i2cwm_pkg::BIT_ACK);
          end
          default: nxt = '0;
        endcase
      end
      default: nxt = '0;
    endcase
    nxt.hold_cycles = delayed ? half : 16'd0;
  end

  assign deq = adv && nxt.last;

  always_comb begin
    phase_next  = phase;
    bitcnt_next = bitcnt;
    if (adv) begin
      case (phase)
        PH_LEAD: phase_next = PH_HIGH;
        PH_HIGH: phase_next = PH_LOW;
        PH_LOW: begin
          phase_next  = PH_LEAD;
          bitcnt_next = (head.cmd.kind == i2cwm_pkg::ACT_BYTE && !nxt.last)
                      ? bitcnt + 4'd1 : 4'd0;
        end
        default: phase_next = PH_LEAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_LEAD;
      bitcnt    <= 4'd0;
      scl_now   <= 1'b1;
      out_valid <= 1'b0;
      half      <= i2cwm_pkg::HALF_PERIOD_RESET;
    end else begin
      phase  <= phase_next;
      bitcnt <= bitcnt_next;
      if (adv) begin
        scl_now   <= nxt.scl_level;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        half <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_reg <= nxt;
    end
  end

  assign empty    = !out_valid;
  assign out_item = out_reg;

  `ASSERT_CLK(a_bit_in_byte, (bitcnt != 4'd0) |-> (head.valid && head.cmd.kind == i2cwm_pkg::ACT_BYTE), "Bit count set outside a byte command.")
  `ASSERT_CLK(a_start_ends_low, (adv && head.cmd.kind == i2cwm_pkg::ACT_START && phase == PH_LOW) |=> !scl_now, "Clock line not low after a start condition.")
  `ASSERT_CLK(a_deq_at_low, deq |-> (phase == PH_LOW), "Command retired outside its final phase.")
  `ASSERT_NEVER(a_bitcnt_range, bitcnt > i2cwm_pkg::BIT_ACK, "Bit count beyond the acknowledge clock.")

endmodule

@@ rtl/i2c_write_master_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// i2c_write_master_sequencer_core
// Write-only I2C master line sequencer. Commands (start, write byte, stop)
// are turned into runs of SCL/SDA line states, each with a hold time.
//
//   Channel  | Direction | Handshake            | Payload
//   ---------+-----------+----------------------+--------------------------
//   command  | in        | push / full          | in_item  (action, data_byte)
//   line     | out       | pop / empty          | out_item (scl, sda, hold, last)
//   config   | in        | cfg_we, no wait      | cfg_wdata (half period)
//
// One line state beat is produced per cycle while results are popped:
// start and stop take 3 beats, a byte 27, set by the three-phase sequencer.
// A command's first beat is held in the queue, then in the result register.
// Up to two commands wait, so pushes continue while results stall until full.
// Reset is synchronous and needs no clearing pass; an unknown action is dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_write_master_sequencer_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  i2cwm_pkg::in_item_t  in_item,
  output logic                 empty,
  input  logic                 pop,
  output i2cwm_pkg::out_item_t out_item,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata
);

  i2cwm_pkg::head_t head;
  logic             deq;

  i2cwm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .head    (head),
    .deq     (deq)
  );

  i2cwm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .deq       (deq),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule
